FILE: rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the websocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KindW = 3;
	localparam int unsigned CodeW = 10;

	// result kinds
	localparam logic [KindW-1:0] KIND_PAYLOAD    = 3'd0;
	localparam logic [KindW-1:0] KIND_MSG_END    = 3'd1;
	localparam logic [KindW-1:0] KIND_PONG_BYTE  = 3'd2;
	localparam logic [KindW-1:0] KIND_PONG_EMPTY = 3'd3;
	localparam logic [KindW-1:0] KIND_CLOSE      = 3'd4;

	// close status codes
	localparam logic [CodeW-1:0] CLOSE_NORMAL    = 10'd1000;
	localparam logic [CodeW-1:0] CLOSE_PROTOCOL  = 10'd1002;
	localparam logic [CodeW-1:0] CLOSE_BAD_DATA  = 10'd1003;
	localparam logic [CodeW-1:0] CLOSE_TOO_BIG   = 10'd1009;
	localparam logic [CodeW-1:0] CLOSE_NONE      = 10'd0;

	typedef struct packed {
		logic             valid;
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] data;
		logic             last;
		logic [CodeW-1:0] code;
	} wsd_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/wsd_parse.sv
// ----------------------------------------------------------------------------
// wsd_parse
// Frame header parser and payload unmasking: per-word state update and result.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parse
	import wsd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             action,
	input  wire logic [ByteW-1:0] data_byte,
	output wsd_res_t              res
);

	localparam logic [3:0] PH_HDR0    = 4'd0;
	localparam logic [3:0] PH_HDR1    = 4'd1;
	localparam logic [3:0] PH_EXT_HI  = 4'd2;
	localparam logic [3:0] PH_EXT_LO  = 4'd3;
	localparam logic [3:0] PH_MASK0   = 4'd4;
	localparam logic [3:0] PH_MASK1   = 4'd5;
	localparam logic [3:0] PH_MASK2   = 4'd6;
	localparam logic [3:0] PH_MASK3   = 4'd7;
	localparam logic [3:0] PH_PAYLOAD = 4'd8;
	localparam logic [3:0] PH_CLOSED  = 4'd9;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [6:0] LEN_EXT16   = 7'd126;
	localparam logic [6:0] LEN_EXT64   = 7'd127;
	localparam logic [15:0] PING_MAX   = 16'd125;

	logic [3:0]  phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic [15:0] left_q, left_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  pos_q, pos_d;

	logic [6:0]  len7;
	logic [15:0] left_dec;
	logic [15:0] ext_len;
	logic [7:0]  key_byte;
	logic [7:0]  unmasked;
	logic        is_data;

	assign len7     = data_byte[6:0];
	assign left_dec = left_q - 16'd1;
	assign ext_len  = {left_q[15:8], data_byte};
	assign key_byte = key_q[{~pos_q, 3'b000} +: 8];
	assign unmasked = data_byte ^ key_byte;
	assign is_data  = (opcode_q == OP_CONT) || (opcode_q == OP_BIN);

	always_comb begin
		phase_d  = phase_q;
		fin_d    = fin_q;
		opcode_d = opcode_q;
		left_d   = left_q;
		key_d    = key_q;
		pos_d    = pos_q;
		res      = '{valid: 1'b0, kind: KIND_PAYLOAD, data: '0, last: 1'b0, code: CLOSE_NONE};

		if (action) begin
			phase_d  = PH_HDR0;
			fin_d    = 1'b0;
			opcode_d = OP_CONT;
			left_d   = '0;
			key_d    = '0;
			pos_d    = '0;
		end else begin
			case (phase_q)
				PH_HDR0: begin
					fin_d    = data_byte[7];
					opcode_d = data_byte[3:0];
					if (data_byte[6:4] != 3'd0) begin
						phase_d = PH_CLOSED;
						res     = '{valid: 1'b1, kind: KIND_CLOSE, data: '0, last: 1'b0,
							code: CLOSE_PROTOCOL};
					end else begin
						phase_d = PH_HDR1;
					end
				end
				PH_HDR1: begin
					if (!data_byte[7] || len7 == LEN_EXT64 || opcode_q == OP_TEXT ||
						opcode_q == OP_CLOSE ||
						!(opcode_q inside {OP_CONT, OP_BIN, OP_PING, OP_PONG})) begin
						phase_d = PH_CLOSED;
						res.valid = 1'b1;
						res.kind  = KIND_CLOSE;
						if (!data_byte[7])
							res.code = CLOSE_PROTOCOL;
						else if (len7 == LEN_EXT64)
							res.code = CLOSE_TOO_BIG;
						else if (opcode_q == OP_TEXT)
							res.code = CLOSE_BAD_DATA;
						else if (opcode_q == OP_CLOSE)
							res.code = CLOSE_NORMAL;
						else
							res.code = CLOSE_PROTOCOL;
					end else if (len7 == LEN_EXT16) begin
						phase_d = PH_EXT_HI;
					end else begin
						left_d  = {9'd0, len7};
						phase_d = PH_MASK0;
					end
				end
				PH_EXT_HI: begin
					left_d  = {data_byte, 8'd0};
					phase_d = PH_EXT_LO;
				end
				PH_EXT_LO: begin
					left_d = ext_len;
					if (opcode_q == OP_PING && ext_len > PING_MAX) begin
						phase_d = PH_CLOSED;
						res     = '{valid: 1'b1, kind: KIND_CLOSE, data: '0, last: 1'b0,
							code: CLOSE_TOO_BIG};
					end else begin
						phase_d = PH_MASK0;
					end
				end
				PH_MASK0, PH_MASK1, PH_MASK2: begin
					key_d   = {key_q[23:0], data_byte};
					phase_d = phase_q + 4'd1;
				end
				PH_MASK3: begin
					key_d = {key_q[23:0], data_byte};
					pos_d = '0;
					if (left_q != 16'd0) begin
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_HDR0;
						if (opcode_q == OP_PING)
							res = '{valid: 1'b1, kind: KIND_PONG_EMPTY, data: '0, last: 1'b1,
								code: CLOSE_NONE};
						else if (is_data && fin_q)
							res = '{valid: 1'b1, kind: KIND_MSG_END, data: '0, last: 1'b1,
								code: CLOSE_NONE};
					end
				end
				PH_PAYLOAD: begin
					pos_d  = pos_q + 2'd1;
					left_d = left_dec;
					if (left_dec == 16'd0)
						phase_d = PH_HDR0;
					if (opcode_q == OP_PING)
						res = '{valid: 1'b1, kind: KIND_PONG_BYTE, data: unmasked,
							last: (left_dec == 16'd0), code: CLOSE_NONE};
					else if (is_data)
						res = '{valid: 1'b1, kind: KIND_PAYLOAD, data: unmasked,
							last: fin_q && (left_dec == 16'd0), code: CLOSE_NONE};
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= OP_CONT;
			left_q   <= '0;
			key_q    <= '0;
			pos_q    <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			left_q   <= left_d;
			key_q    <= key_d;
			pos_q    <= pos_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/wsd_out.sv
// ----------------------------------------------------------------------------
// wsd_out
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_out
	import wsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire wsd_res_t          res,
	output logic                   slot_free,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic [KindW-1:0]       kind,
	output logic [ByteW-1:0]       out_byte,
	output logic                   message_last,
	output logic [CodeW-1:0]       close_code
);

	logic             valid_q;
	logic [KindW-1:0] kind_q;
	logic [ByteW-1:0] byte_q;
	logic             last_q;
	logic [CodeW-1:0] code_q;

	assign slot_free = !valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && advance && res.valid) begin
			kind_q <= res.kind;
			byte_q <= res.data;
			last_q <= res.last;
			code_q <= res.code;
		end
	end

	assign rsp_valid    = valid_q;
	assign kind         = kind_q;
	assign out_byte     = byte_q;
	assign message_last = last_q;
	assign close_code   = code_q;

endmodule

`default_nettype wire

FILE: rtl/core/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Client-to-server websocket frame receiver: header parse, unmask, pong echo.
//
//  channel  signals                                   direction
//  req      req_valid req_ready action data_byte      in
//  rsp      rsp_valid rsp_ready kind out_byte
//           message_last close_code                   out
//
//  one word accepted per cycle while req_ready is high; each word passes an
//  input register, the header/unmask logic and the result register. the
//  result is registered and offered as the input register advances. arst_n
//  clears the parser to await a first header byte and empties both
//  registers. a stalled result holds the input register, so req_ready
//  drops only when both registers are full and rsp_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_top
	import wsd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire logic             action,
	input  wire logic [ByteW-1:0] data_byte,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output logic [KindW-1:0]      kind,
	output logic [ByteW-1:0]      out_byte,
	output logic                  message_last,
	output logic [CodeW-1:0]      close_code
);

	logic             valid_s1;
	logic             action_s1;
	logic [ByteW-1:0] byte_s1;
	logic             slot_free;
	logic             advance;
	wsd_res_t         res;

	assign advance   = valid_s1 && slot_free;
	assign req_ready = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			action_s1 <= action;
			byte_s1   <= data_byte;
		end
	end

	wsd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.action    (action_s1),
		.data_byte (byte_s1),
		.res       (res)
	);

	wsd_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.res          (res),
		.slot_free    (slot_free),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.kind         (kind),
		.out_byte     (out_byte),
		.message_last (message_last),
		.close_code   (close_code)
	);

endmodule

`default_nettype wire

FILE: rtl/core/wsd_check.sv
// ----------------------------------------------------------------------------
// wsd_check
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_check
	import wsd_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_ready,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic [KindW-1:0] kind,
	input wire logic [ByteW-1:0] out_byte,
	input wire logic             message_last,
	input wire logic [CodeW-1:0] close_code
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(out_byte) &&
			$stable(message_last) && $stable(close_code))
		else $error("result changed while stalled");

	// close results carry a known code and no last mark
	a_close_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_CLOSE |-> !message_last &&
			(close_code == CLOSE_NORMAL || close_code == CLOSE_PROTOCOL ||
			 close_code == CLOSE_BAD_DATA || close_code == CLOSE_TOO_BIG))
		else $error("bad close result");

	// empty message or pong ends carry last and a zero byte
	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (kind == KIND_MSG_END || kind == KIND_PONG_EMPTY) |->
			message_last && out_byte == 8'd0 && close_code == CLOSE_NONE)
		else $error("bad empty end result");

	// non-close results have no close code
	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (kind == KIND_PAYLOAD || kind == KIND_PONG_BYTE) |->
			close_code == CLOSE_NONE)
		else $error("close code on data result");

	// input not ready only while a result is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled without output stall");

endmodule

bind websocket_frame_deframer_top wsd_check u_check (.*);

`default_nettype wire

FILE: tb/tb_websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_top
// Self-checking bench for the websocket frame deframer. Client frames are
// streamed in byte by byte: a short directed set first, then random
// well-formed frames mixed with protocol violations, truncated frames and
// reconnects. A scoreboard parses every accepted word on its own and holds
// the results it predicts. Each result leaving the block is checked field by
// field against the oldest one waiting. Both channels idle and stall in
// random bursts, except during the directed set and the closing stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_websocket_frame_deframer_top;

	import wsd_pkg::*;

	localparam logic [3:0] OPC_CONT  = 4'h0;
	localparam logic [3:0] OPC_TEXT  = 4'h1;
	localparam logic [3:0] OPC_BIN   = 4'h2;
	localparam logic [3:0] OPC_CLOSE = 4'h8;
	localparam logic [3:0] OPC_PING  = 4'h9;
	localparam logic [3:0] OPC_PONG  = 4'hA;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam int WORD_TARGET = 1550;
	localparam int CALM_AFTER  = 1350;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [3:0] {
		P_HDR0, P_HDR1, P_EXT_HI, P_EXT_LO,
		P_KEY0, P_KEY1, P_KEY2, P_KEY3,
		P_PAYLOAD, P_CLOSED
	} parse_phase_e;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] data;
		logic             last;
		logic [CodeW-1:0] code;
	} ws_result_t;

	class frame_scoreboard;
		parse_phase_e phase;
		logic         fin;
		logic [3:0]   opcode;
		logic [15:0]  bytes_left;
		logic [31:0]  mask_key;
		logic [1:0]   key_index;
		logic         message_open;
		ws_result_t   awaited_results[$];
		int           mismatch_count;

		function new();
			mismatch_count = 0;
			reset_state();
		endfunction

		function void reset_state();
			phase = P_HDR0;
			fin = 1'b0;
			opcode = 4'h0;
			bytes_left = 16'h0;
			mask_key = 32'h0;
			key_index = 2'd0;
			message_open = 1'b0;
		endfunction

		function void push_result(logic [KindW-1:0] k, logic [ByteW-1:0] d, logic l,
			logic [CodeW-1:0] c);
			ws_result_t r;
			r.kind = k;
			r.data = d;
			r.last = l;
			r.code = c;
			awaited_results = {awaited_results, r};
		endfunction

		function void close_link(logic [CodeW-1:0] c);
			phase = P_CLOSED;
			push_result(KIND_CLOSE, 8'h00, 1'b0, c);
		endfunction

		function bit is_data();
			return opcode == OPC_CONT || opcode == OPC_BIN;
		endfunction

		function void parse_word(logic act, logic [ByteW-1:0] b);
			logic [6:0] len7;
			logic [7:0] unmasked;
			logic       at_end;
			int         shift;
			if (act) begin
				reset_state();
				return;
			end
			case (phase)
				P_HDR0: begin
					fin = b[7];
					opcode = b[3:0];
					if (b[6:4] != 3'd0)
						close_link(CLOSE_PROTOCOL);
					else
						phase = P_HDR1;
				end
				P_HDR1: begin
					len7 = b[6:0];
					if (!b[7])
						close_link(CLOSE_PROTOCOL);
					else if (len7 == LEN_EXT64)
						close_link(CLOSE_TOO_BIG);
					else if (opcode == OPC_TEXT)
						close_link(CLOSE_BAD_DATA);
					else if (opcode == OPC_CLOSE)
						close_link(CLOSE_NORMAL);
					else if (!is_data() && opcode != OPC_PING && opcode != OPC_PONG)
						close_link(CLOSE_PROTOCOL);
					else if (len7 == LEN_EXT16)
						phase = P_EXT_HI;
					else begin
						bytes_left = {9'd0, len7};
						phase = P_KEY0;
					end
				end
				P_EXT_HI: begin
					bytes_left = {b, 8'h00};
					phase = P_EXT_LO;
				end
				P_EXT_LO: begin
					bytes_left[7:0] = b;
					if (opcode == OPC_PING && bytes_left > 16'd125)
						close_link(CLOSE_TOO_BIG);
					else
						phase = P_KEY0;
				end
				P_KEY0, P_KEY1, P_KEY2: begin
					mask_key = {mask_key[23:0], b};
					phase = parse_phase_e'(phase + 4'd1);
				end
				P_KEY3: begin
					mask_key = {mask_key[23:0], b};
					key_index = 2'd0;
					if (bytes_left != 16'd0)
						phase = P_PAYLOAD;
					else begin
						phase = P_HDR0;
						if (opcode == OPC_PING)
							push_result(KIND_PONG_EMPTY, 8'h00, 1'b1, CLOSE_NONE);
						else if (is_data()) begin
							if (fin) begin
								message_open = 1'b0;
								push_result(KIND_MSG_END, 8'h00, 1'b1, CLOSE_NONE);
							end else
								message_open = 1'b1;
						end
					end
				end
				P_PAYLOAD: begin
					shift = 8 * (3 - int'(key_index));
					unmasked = b ^ 8'(mask_key >> shift);
					key_index = key_index + 2'd1;
					bytes_left = bytes_left - 16'd1;
					at_end = (bytes_left == 16'd0);
					if (at_end)
						phase = P_HDR0;
					if (opcode == OPC_PING)
						push_result(KIND_PONG_BYTE, unmasked, at_end, CLOSE_NONE);
					else if (is_data()) begin
						if (fin && at_end) begin
							message_open = 1'b0;
							push_result(KIND_PAYLOAD, unmasked, 1'b1, CLOSE_NONE);
						end else begin
							message_open = 1'b1;
							push_result(KIND_PAYLOAD, unmasked, 1'b0, CLOSE_NONE);
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			mismatch_count++;
			if (mismatch_count <= 40)
				$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		task check_result(logic [KindW-1:0] k, logic [ByteW-1:0] d, logic l,
			logic [CodeW-1:0] c);
			ws_result_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d byte %02h code %0d", k, d, c));
				return;
			end
			want = awaited_results.pop_front();
			if (k !== want.kind)
				report($sformatf("kind %0d, expected %0d", k, want.kind));
			if (d !== want.data)
				report($sformatf("out_byte %02h, expected %02h", d, want.data));
			if (l !== want.last)
				report($sformatf("message_last %0b, expected %0b", l, want.last));
			if (c !== want.code)
				report($sformatf("close_code %0d, expected %0d", c, want.code));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	logic             action;
	logic [ByteW-1:0] data_byte;
	logic             rsp_valid;
	logic             rsp_ready;
	logic [KindW-1:0] kind;
	logic [ByteW-1:0] out_byte;
	logic             message_last;
	logic [CodeW-1:0] close_code;

	frame_scoreboard sb;
	int              words_sent;
	int              req_idle_pct;
	int              rsp_idle_pct;
	int              cycle_count;

	websocket_frame_deframer_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.action       (action),
		.data_byte    (data_byte),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.kind         (kind),
		.out_byte     (out_byte),
		.message_last (message_last),
		.close_code   (close_code)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// accepted words on both channels
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready)
			sb.parse_word(action, data_byte);
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(kind, out_byte, message_last, close_code);
	end

	// result side stalls
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (rsp_idle_pct != 0 && $urandom_range(1, 100) <= rsp_idle_pct) begin
				rsp_ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else
				rsp_ready <= 1'b1;
		end
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(logic act, logic [ByteW-1:0] b);
		int gap;
		words_sent++;
		if (req_idle_pct != 0 && $urandom_range(1, 100) <= req_idle_pct) begin
			gap = $urandom_range(1, 4);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic close_tail();
		int n;
		n = $urandom_range(0, 2);
		repeat (n) send_word(1'b0, 8'($urandom));
		send_word(1'b1, 8'($urandom));
	endtask

	task automatic send_frame(logic [7:0] hdr0, logic masked, logic [6:0] len7,
		logic [15:0] ext_len, bit use_fixed, logic [7:0] fixed);
		int count;
		send_word(1'b0, hdr0);
		if (sb.phase == P_CLOSED) begin
			close_tail();
			return;
		end
		send_word(1'b0, {masked, len7});
		if (sb.phase == P_CLOSED) begin
			close_tail();
			return;
		end
		count = len7;
		if (len7 == LEN_EXT16) begin
			count = ext_len;
			send_word(1'b0, ext_len[15:8]);
			send_word(1'b0, ext_len[7:0]);
			if (sb.phase == P_CLOSED) begin
				close_tail();
				return;
			end
		end
		repeat (4) send_word(1'b0, use_fixed ? fixed : 8'($urandom));
		for (int i = 0; i < count; i++) begin
			if (!use_fixed && $urandom_range(0, 199) == 0) begin
				send_word(1'b1, 8'($urandom));
				return;
			end
			send_word(1'b0, use_fixed ? fixed : 8'($urandom));
		end
	endtask

	task automatic send_normal_frame();
		logic [3:0]  opc;
		logic        fin;
		logic [6:0]  len7;
		logic [15:0] ext_len;
		int          r;
		r = $urandom_range(0, 99);
		opc = (r < 25) ? OPC_CONT : (r < 60) ? OPC_BIN : (r < 80) ? OPC_PING : OPC_PONG;
		fin = ($urandom_range(0, 9) < 6);
		ext_len = 16'd0;
		r = $urandom_range(0, 99);
		if (r < 80)
			len7 = 7'($urandom_range(0, 12));
		else if (r < 90)
			len7 = 7'($urandom_range(13, 125));
		else begin
			len7 = LEN_EXT16;
			if (opc == OPC_PING)
				ext_len = 16'($urandom_range(0, 125));
			else if (r == 99)
				ext_len = 16'($urandom_range(1000, 1200));
			else
				ext_len = 16'($urandom_range(126, 300));
		end
		send_frame({fin, 3'b000, opc}, 1'b1, len7, ext_len, 1'b0, 8'h00);
	endtask

	task automatic send_special_frame();
		logic [7:0]  hdr0;
		logic        masked;
		logic [6:0]  len7;
		logic [15:0] ext_len;
		logic [3:0]  opc;
		masked = 1'b1;
		len7 = 7'($urandom_range(0, 8));
		ext_len = 16'($urandom_range(0, 300));
		opc = ($urandom_range(0, 1) == 1) ? OPC_BIN : OPC_CONT;
		hdr0 = {1'($urandom), 3'b000, opc};
		case ($urandom_range(0, 9))
			0: hdr0[6:4] = 3'($urandom_range(1, 7));
			1: masked = 1'b0;
			2: len7 = LEN_EXT64;
			3: hdr0[3:0] = OPC_TEXT;
			4: hdr0[3:0] = OPC_CLOSE;
			5: hdr0[3:0] = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(3, 7))
				: 4'($urandom_range(11, 15));
			6: begin
				hdr0[3:0] = OPC_PING;
				len7 = LEN_EXT16;
				ext_len = 16'($urandom_range(126, 65535));
			end
			7: begin
				len7 = LEN_EXT16;
				ext_len = 16'($urandom_range(0, 125));
				if ($urandom_range(0, 2) == 0)
					hdr0[3:0] = OPC_PONG;
			end
			8: begin
				hdr0[7] = 1'b0;
				hdr0[3:0] = ($urandom_range(0, 1) == 1) ? OPC_PING : OPC_PONG;
			end
			default: begin
				hdr0 = 8'($urandom);
				masked = 1'($urandom);
				len7 = 7'($urandom);
			end
		endcase
		send_frame(hdr0, masked, len7, ext_len, 1'b0, 8'h00);
	endtask

	initial begin
		sb = new();
		words_sent = 0;
		cycle_count = 0;
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		action = 1'b0;
		data_byte = 8'h00;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed
		send_word(1'b1, 8'hFF);
		send_frame({1'b1, 3'b000, OPC_BIN}, 1'b1, 7'd2, 16'd0, 1'b1, 8'hFF);
		send_frame({1'b1, 3'b000, OPC_PING}, 1'b1, 7'd1, 16'd0, 1'b1, 8'h00);
		send_frame({1'b1, 3'b000, OPC_BIN}, 1'b1, 7'd0, 16'd0, 1'b1, 8'h5A);
		send_frame({1'b1, 3'b111, OPC_BIN}, 1'b1, 7'd0, 16'd0, 1'b1, 8'h00);

		// random
		while (words_sent < WORD_TARGET) begin
			if (words_sent >= CALM_AFTER) begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end else if ($urandom_range(0, 9) == 0) begin
				req_idle_pct = 20 * $urandom_range(0, 2);
				rsp_idle_pct = 20 * $urandom_range(0, 2);
			end
			if ($urandom_range(0, 99) < 3)
				send_word(1'b1, 8'($urandom));
			else if ($urandom_range(0, 99) < 75)
				send_normal_frame();
			else
				send_special_frame();
		end

		req_valid <= 1'b0;
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/wsd_pkg.sv
rtl/core/wsd_parse.sv
rtl/core/wsd_out.sv
rtl/core/websocket_frame_deframer_top.sv
rtl/core/wsd_check.sv
tb/tb_websocket_frame_deframer_top.sv
